### hw/rtl/cgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgd_pkg
// Shared types and constants for the crank gap decoder and spark/injection timer.
// ----------------------------------------------------------------------------
package cgd_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned SHORT_W  = 16;
	localparam int unsigned ANGLE_W  = 10;
	localparam int unsigned GAP_W    = TIME_W + 5;
	localparam int unsigned IN_W     = 128;
	localparam int unsigned OUT_W    = 48;
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned DEGREES_PER_TOOTH_DEF = 6;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;

	localparam logic [SHORT_W-1:0] COIL_CHARGE_RST = 16'd3000;
	localparam logic [SHORT_W-1:0] INJ_OPEN_RST    = 16'd1700;

	localparam logic [CFG_IDX_W-1:0] REG_COIL_CHARGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INJ_OPEN    = 1'd1;

	// per-item work carried from the input stage to the decode stage
	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] inj_on_thr;
		logic [TIME_W-1:0] inj_off_thr;
		logic [TIME_W-1:0] coil_on_thr;
		logic [TIME_W-1:0] coil_off_thr;
	} cgd_work_t;

	// handshake between the input stage and the decode stage
	typedef struct packed {
		logic valid;
		logic take;
	} cgd_hs_t;

endpackage

### hw/rtl/cgd_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgd_prep
// Config registers and input stage: unpacks an item and forms its thresholds.
// ----------------------------------------------------------------------------
module cgd_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cgd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cgd_pkg::SHORT_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cgd_pkg::IN_W-1:0]      s_tdata,
	input  logic                          take,
	output logic                          valid_s1,
	output cgd_pkg::cgd_work_t            work_s1
);
	import cgd_pkg::*;

	logic [SHORT_W-1:0] coil_charge_q;
	logic [SHORT_W-1:0] inj_open_q;
	logic               valid_q;
	cgd_work_t          work_d;

	logic [TIME_W-1:0]  edge_time_us;
	logic [TIME_W-1:0]  inj_start_us;
	logic [SHORT_W-1:0] inj_useful_us;
	logic [TIME_W-1:0]  tdc_us;
	logic [SHORT_W-1:0] advance_us;
	logic [TIME_W-1:0]  spark_time;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_charge_q <= COIL_CHARGE_RST;
			inj_open_q    <= INJ_OPEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COIL_CHARGE: coil_charge_q <= cfg_data;
				REG_INJ_OPEN:    inj_open_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign edge_time_us  = s_tdata[31:0];
	assign inj_start_us  = s_tdata[63:32];
	assign inj_useful_us = s_tdata[79:64];
	assign tdc_us        = s_tdata[111:80];
	assign advance_us    = s_tdata[127:112];

	assign spark_time = tdc_us - {16'd0, advance_us};

	always_comb begin
		work_d.now          = edge_time_us;
		work_d.inj_on_thr   = inj_start_us;
		work_d.inj_off_thr  = inj_start_us + {16'd0, inj_open_q} + {16'd0, inj_useful_us};
		work_d.coil_on_thr  = spark_time - {16'd0, coil_charge_q};
		work_d.coil_off_thr = spark_time;
	end

	assign s_tready = !valid_q || take;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1 <= work_d;
		end
	end

	assign valid_s1 = valid_q;

endmodule

### hw/rtl/cgd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgd_core
// Gap detection, angle count, phase and injector/coil windows; result register.
// ----------------------------------------------------------------------------
module cgd_core #(
	parameter int unsigned DEGREES_PER_TOOTH = cgd_pkg::DEGREES_PER_TOOTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  cgd_pkg::cgd_work_t        work_s1,
	output logic                      take,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [cgd_pkg::OUT_W-1:0] m_tdata
);
	import cgd_pkg::*;

	logic [TIME_W-1:0]  last_edge_q;
	logic [GAP_W-1:0]   prev_x21_q;
	logic [ANGLE_W-1:0] angle_q;
	logic               pend_q;
	logic               phase_q;
	logic [TIME_W-1:0]  ref_q;
	logic               armed_q;
	logic               inj_q;
	logic               coil_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic [TIME_W-1:0]  period;
	logic [GAP_W-1:0]   period_x20;
	logic [GAP_W-1:0]   period_x21;
	logic               gap;
	logic [ANGLE_W:0]   angle_sum;
	logic [ANGLE_W-1:0] angle_d;
	logic               phase_d;
	logic               armed_d;
	logic [TIME_W-1:0]  ref_d;
	logic [TIME_W-1:0]  elapsed;
	logic               inj_d;
	logic               coil_d;
	cgd_hs_t            hs;

	assign hs.valid = valid_s1;
	assign hs.take  = valid_s1 && (!out_valid_q || m_tready);
	assign take     = hs.take;

	assign period     = work_s1.now - last_edge_q;
	assign period_x20 = {1'b0, period, 4'd0} + {3'd0, period, 2'd0};
	assign period_x21 = period_x20 + {5'd0, period};
	assign gap        = period_x20 > prev_x21_q;

	assign angle_sum = {1'b0, angle_q} + (ANGLE_W+1)'(DEGREES_PER_TOOTH);

	always_comb begin
		if (gap) begin
			angle_d = '0;
		end else if (angle_sum > {1'b0, ANGLE_MAX}) begin
			angle_d = ANGLE_MAX;
		end else begin
			angle_d = angle_sum[ANGLE_W-1:0];
		end
	end

	// pending gap restarts the reference on this edge
	assign phase_d = phase_q ^ pend_q;
	assign ref_d   = pend_q ? work_s1.now : ref_q;
	assign elapsed = pend_q ? '0 : (work_s1.now - ref_q);

	always_comb begin
		armed_d = armed_q || pend_q;
		inj_d   = inj_q;
		if (!phase_d && armed_d) begin
			if (elapsed >= work_s1.inj_on_thr) begin
				inj_d = 1'b1;
			end
			if (elapsed >= work_s1.inj_off_thr) begin
				inj_d   = 1'b0;
				armed_d = 1'b0;
			end
		end
	end

	always_comb begin
		coil_d = coil_q;
		if (elapsed >= work_s1.coil_on_thr) begin
			coil_d = 1'b1;
		end
		if (elapsed >= work_s1.coil_off_thr) begin
			coil_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			prev_x21_q  <= '0;
			angle_q     <= '0;
			pend_q      <= 1'b0;
			phase_q     <= 1'b0;
			ref_q       <= '0;
			armed_q     <= 1'b0;
			inj_q       <= 1'b0;
			coil_q      <= 1'b0;
		end else if (hs.take) begin
			last_edge_q <= work_s1.now;
			prev_x21_q  <= period_x21;
			angle_q     <= angle_d;
			pend_q      <= gap;
			phase_q     <= phase_d;
			ref_q       <= ref_d;
			armed_q     <= armed_d;
			inj_q       <= inj_d;
			coil_q      <= coil_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= hs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hs.take) begin
			out_data_q <= {2'd0, period, gap, phase_d, angle_d, coil_d, inj_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### hw/rtl/crank_gap_decoder_spark_injection_timer_core.sv
`timescale 1ns / 1ps
// Path: an accepted item is registered in the input stage, then in the result register.
// Throughput: one item per cycle while the result side accepts; the tooth state updates once per accepted item.
// Reset: arst_n clears all tooth, phase and drive state to zero and loads the
// config registers with 3000 us coil charge and 1700 us injector opening.
// ----------------------------------------------------------------------------
// crank_gap_decoder_spark_injection_timer_core
// Missing-tooth crank decoder with injector and ignition coil timing.
// ----------------------------------------------------------------------------
module crank_gap_decoder_spark_injection_timer_core #(
	parameter int unsigned DEGREES_PER_TOOTH = cgd_pkg::DEGREES_PER_TOOTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cgd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cgd_pkg::SHORT_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// edge_time_us[31:0], inj_start_us[63:32], inj_useful_us[79:64],
	// tdc_us[111:80], advance_us[127:112]
	input  logic [cgd_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// injector_on[0], coil_on[1], crank_angle[11:2], cycle_phase[12],
	// gap_found[13], tooth_period_us[45:14], zero[47:46]
	output logic [cgd_pkg::OUT_W-1:0]     m_tdata
);
	import cgd_pkg::*;

	cgd_work_t work_s1;
	logic      valid_s1;
	logic      take;

	cgd_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.work_s1  (work_s1)
	);

	cgd_core #(
		.DEGREES_PER_TOOTH (DEGREES_PER_TOOTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.work_s1  (work_s1),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### hw/rtl/cgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgd_checker
// Port-level checks for the crank gap decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cgd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [cgd_pkg::OUT_W-1:0] m_tdata
);
	import cgd_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// empty result register never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// a gap clears the angle
	a_gap_angle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[11:2] == '0)
		else $error("angle not cleared on gap");

	// a gap needs a nonzero period
	a_gap_period: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[45:14] != '0)
		else $error("gap with zero period");

endmodule

bind crank_gap_decoder_spark_injection_timer_core cgd_checker u_cgd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### bench/tb_crank_gap_decoder_spark_injection_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crank_gap_decoder_spark_injection_timer_core
// Drives crank tooth items into the decoder and checks every result against a
// cycle-free model of the tooth, gap, phase, injector and coil logic. Runs
// directed edge cases, then well-formed wheels with random tooth counts,
// speeds and timing targets, mixed with random noise items, under several
// register settings. Random idling on both sides, plus one long result hold-off.
// ----------------------------------------------------------------------------
module tb_crank_gap_decoder_spark_injection_timer_core;
	import cgd_pkg::*;

	localparam int unsigned LIMIT       = 600000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned ITEMS       = 2000;
	localparam int unsigned DEG         = DEGREES_PER_TOOTH_DEF;

	// fields from the lowest bit up: edge_time, inj_start, inj_useful, tdc, advance
	typedef struct packed {
		logic [SHORT_W-1:0] advance;
		logic [TIME_W-1:0]  tdc;
		logic [SHORT_W-1:0] inj_useful;
		logic [TIME_W-1:0]  inj_start;
		logic [TIME_W-1:0]  edge_time;
	} tooth_t;

	typedef struct packed {
		logic [1:0]         pad;
		logic [TIME_W-1:0]  period;
		logic               gap;
		logic               phase;
		logic [ANGLE_W-1:0] angle;
		logic               coil;
		logic               injector;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [SHORT_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	// decoder model state
	logic [SHORT_W-1:0] coil_charge = COIL_CHARGE_RST;
	logic [SHORT_W-1:0] inj_open    = INJ_OPEN_RST;
	logic [TIME_W-1:0]  last_edge   = '0;
	logic [TIME_W-1:0]  last_period = '0;
	logic [TIME_W-1:0]  ref_time    = '0;
	logic [ANGLE_W-1:0] angle       = '0;
	logic gap_pending = 1'b0;
	logic phase       = 1'b0;
	logic inj_armed   = 1'b0;
	logic inj_level   = 1'b0;
	logic coil_level  = 1'b0;

	drive_t drive_queue[$];
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	logic [TIME_W-1:0] wheel_time = 32'hFFF0_0000;
	bit src_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	bit hold_req = 1'b0;

	crank_gap_decoder_spark_injection_timer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	function automatic drive_t decode_tooth(tooth_t t);
		drive_t r;
		logic [TIME_W-1:0] prev, period, elapsed, inj_off_at, coil_off_at, coil_on_at;
		logic [ANGLE_W:0] sum;
		logic gap;
		prev = last_period;
		period = t.edge_time - last_edge;
		last_period = period;
		last_edge = t.edge_time;
		sum = {1'b0, angle} + (ANGLE_W+1)'(DEG);
		angle = (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[ANGLE_W-1:0];
		if (gap_pending) begin
			gap_pending = 1'b0;
			ref_time = t.edge_time;
			inj_armed = 1'b1;
			phase = ~phase;
		end
		gap = (64'(period) * 64'd20) > (64'(prev) * 64'd21);
		if (gap) begin
			gap_pending = 1'b1;
			angle = '0;
		end
		elapsed = t.edge_time - ref_time;
		inj_off_at = t.inj_start + TIME_W'(inj_open) + TIME_W'(t.inj_useful);
		coil_off_at = t.tdc - TIME_W'(t.advance);
		coil_on_at = coil_off_at - TIME_W'(coil_charge);
		if (!phase && inj_armed) begin
			if (elapsed >= t.inj_start)
				inj_level = 1'b1;
			if (elapsed >= inj_off_at) begin
				inj_level = 1'b0;
				inj_armed = 1'b0;
			end
		end
		if (elapsed >= coil_on_at)
			coil_level = 1'b1;
		if (elapsed >= coil_off_at)
			coil_level = 1'b0;
		r.pad = '0;
		r.period = period;
		r.gap = gap;
		r.phase = phase;
		r.angle = angle;
		r.coil = coil_level;
		r.injector = inj_level;
		return r;
	endfunction

	function automatic void check_field(string name, logic [TIME_W-1:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		drive_t want, got;
		cycles++;
		if (cycles == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = drive_t'(m_tdata);
				if (drive_queue.size() == 0) begin
					$error("unexpected result item %h", m_tdata);
					errors++;
				end else begin
					want = drive_queue.pop_front();
					check_field("injector_on", TIME_W'(want.injector), TIME_W'(got.injector));
					check_field("coil_on", TIME_W'(want.coil), TIME_W'(got.coil));
					check_field("crank_angle", TIME_W'(want.angle), TIME_W'(got.angle));
					check_field("cycle_phase", TIME_W'(want.phase), TIME_W'(got.phase));
					check_field("gap_found", TIME_W'(want.gap), TIME_W'(got.gap));
					check_field("tooth_period_us", want.period, got.period);
					check_field("pad", TIME_W'(want.pad), TIME_W'(got.pad));
				end
			end
			if (s_tvalid && s_tready)
				drive_queue.push_back(decode_tooth(tooth_t'(s_tdata)));
		end
	end

	// result side: random stalls, and one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_stalls && $urandom_range(0, 6) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	task automatic send_tooth(input logic [TIME_W-1:0] edge_time, inj_start,
			input logic [SHORT_W-1:0] inj_useful, input logic [TIME_W-1:0] tdc,
			input logic [SHORT_W-1:0] advance);
		tooth_t t;
		t.edge_time = edge_time;
		t.inj_start = inj_start;
		t.inj_useful = inj_useful;
		t.tdc = tdc;
		t.advance = advance;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tdata = t;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		items_sent++;
	endtask

	task automatic send_noise();
		send_tooth($urandom, $urandom, 16'($urandom), $urandom, 16'($urandom));
	endtask

	task automatic drain();
		while (drive_queue.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_timing(input logic [SHORT_W-1:0] charge, open_us);
		drain();
		cfg_idx = REG_COIL_CHARGE;
		cfg_data = charge;
		cfg_we = 1'b1;
		@(negedge clk);
		coil_charge = charge;
		cfg_idx = REG_INJ_OPEN;
		cfg_data = open_us;
		@(negedge clk);
		inj_open = open_us;
		cfg_we = 1'b0;
	endtask

	// revs wheel turns, each of teeth-1 even teeth with small jitter, then the missing-tooth gap
	task automatic spin_wheel(input int unsigned teeth, base, revs);
		int unsigned rev_us, step;
		logic [TIME_W-1:0] inj_start, tdc;
		logic [SHORT_W-1:0] useful, adv;
		rev_us = teeth * base;
		for (int r = 0; r < revs; r++) begin
			inj_start = $urandom_range(0, rev_us);
			useful = 16'($urandom_range(0, (rev_us / 2 > 65535) ? 65535 : rev_us / 2));
			tdc = $urandom_range(0, rev_us);
			adv = 16'($urandom_range(0, (rev_us / 4 > 65535) ? 65535 : rev_us / 4));
			for (int k = 0; k < teeth; k++) begin
				if (k == teeth - 1)
					step = base * $urandom_range(2, 3);
				else
					step = base + $urandom_range(0, base / 25);
				if ($urandom_range(0, 15) == 0)
					tdc = $urandom_range(0, rev_us);
				wheel_time = wheel_time + step;
				send_tooth(wheel_time, inj_start, useful, tdc, adv);
			end
		end
	endtask

	task automatic test_first_edges();
		send_tooth(32'd0, 32'd0, 16'd0, 32'd0, 16'd0);
		send_tooth(32'd1000, 32'd0, 16'd500, 32'd5000, 16'd100);
		send_tooth(32'd2000, 32'd0, 16'd500, 32'd5000, 16'd100);
		send_tooth(32'd3000, 32'd0, 16'd500, 32'd5000, 16'd100);
		send_tooth(32'd4000, 32'd0, 16'd500, 32'd5000, 16'd100);
		send_tooth(32'd6500, 32'd0, 16'd500, 32'd5000, 16'd100);
		send_tooth(32'd7500, 32'd0, 16'd500, 32'd2500, 16'd100);
		send_tooth(32'd8500, 32'd0, 16'd500, 32'd2500, 16'd100);
		send_tooth(32'd9500, 32'd0, 16'd500, 32'd2500, 16'd100);
		send_tooth(32'd10500, 32'd0, 16'd500, 32'd2500, 16'd100);
	endtask

	task automatic test_gap_threshold();
		send_tooth(32'd11500, 32'd100, 16'd50, 32'd900, 16'd10);
		send_tooth(32'd12550, 32'd100, 16'd50, 32'd900, 16'd10);
		send_tooth(32'd13550, 32'd100, 16'd50, 32'd900, 16'd10);
		send_tooth(32'd14601, 32'd100, 16'd50, 32'd900, 16'd10);
		send_tooth(32'd15601, 32'd100, 16'd50, 32'd900, 16'd10);
		send_tooth(32'd18601, 32'd100, 16'd50, 32'd900, 16'd10);
		// gap on the edge that also consumes the pending flag
		send_tooth(32'd27601, 32'd100, 16'd50, 32'd900, 16'd10);
	endtask

	task automatic test_field_extremes();
		set_timing(16'hFFFF, 16'd0);
		send_tooth(32'd27600, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_tooth(32'd30000, 32'hFFFF_FF00, 16'hFFFF, 32'd10, 16'hFFFF);
		set_timing(16'd0, 16'hFFFF);
		send_tooth(32'hFFFF_FFFF, 32'hFFFF_FF00, 16'hFFFF, 32'd0, 16'd0);
		send_tooth(32'd5, 32'd0, 16'd0, 32'hFFFF_FFFF, 16'd0);
		send_tooth(32'd5, 32'h8000_0000, 16'h8000, 32'h8000_0000, 16'h8000);
	endtask

	task automatic test_angle_saturation();
		set_timing(COIL_CHARGE_RST, INJ_OPEN_RST);
		spin_wheel(190, $urandom_range(100, 500), 1);
	endtask

	task automatic test_result_holdoff();
		drain();
		src_gaps = 1'b0;
		hold_req = 1'b1;
		spin_wheel(24, 500, 2);
		src_gaps = 1'b1;
	endtask

	task automatic test_random_engine();
		int unsigned phase_end, teeth, base, run_start;
		run_start = items_sent;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_timing(16'd0, 16'd0);
				1: set_timing(16'hFFFF, 16'hFFFF);
				2: set_timing(COIL_CHARGE_RST, INJ_OPEN_RST);
				default: set_timing(16'($urandom_range(0, 8000)),
					16'($urandom_range(0, 4000)));
			endcase
			src_gaps = (ph != 7) && ($urandom_range(0, 3) != 0);
			rx_stalls = (ph != 7) && ($urandom_range(0, 3) != 0);
			phase_end = run_start + ((ITEMS - run_start) * (ph + 1)) / 8;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 4)) send_noise();
				end else begin
					teeth = $urandom_range(3, 36);
					base = ($urandom_range(0, 7) == 0) ? $urandom_range(5000, 60000)
						: $urandom_range(40, 3000);
					spin_wheel(teeth, base, $urandom_range(1, 4));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_first_edges();
		test_gap_threshold();
		test_field_extremes();
		test_angle_saturation();
		test_result_holdoff();
		test_random_engine();
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
